// File: sv/pta_pkg.sv
`default_nettype none
package pta_pkg;

  localparam int POS_W          = 24;
  localparam int ANG_W          = 16;
  localparam int DIFF_W         = POS_W + 1;
  localparam int SQ_W           = 2 * DIFF_W;
  localparam int ROOT_W         = DIFF_W;
  localparam int CIN_W          = DIFF_W + 1;
  localparam int VEC_W          = 48;
  localparam int VEC_SHIFT      = 20;
  localparam int ACC_W          = 28;
  localparam int ACC_FRAC_SHIFT = 11;
  localparam int TABLE_LEN      = 24;

  localparam int OUT_PI      = 25736;
  localparam int OUT_HALF_PI = 12868;
  localparam int ACC_HALF_PI = 26353589;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int YAW_DEADBAND_DEF  = 7;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = POS_W;

  localparam logic [CFG_IDX_W-1:0] REG_PIVOT_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PIVOT_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIVOT_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_MIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_MAX = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_YAW_MIN   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_YAW_MAX   = 3'd6;

  typedef struct packed {
    logic valid;
    logic zero_range;
    logic in_deadband;
    logic dz_pos;
    logic dz_neg;
  } side_t;

  // atan(2^-i), 2^-24 rad
  function automatic logic signed [ACC_W-1:0] atan_entry(input int i);
    logic signed [ACC_W-1:0] v;
    case (i)
      0:       v = ACC_W'(13176795);
      1:       v = ACC_W'(7778716);
      2:       v = ACC_W'(4110060);
      3:       v = ACC_W'(2086331);
      4:       v = ACC_W'(1047214);
      5:       v = ACC_W'(524117);
      6:       v = ACC_W'(262123);
      7:       v = ACC_W'(131069);
      8:       v = ACC_W'(65536);
      9:       v = ACC_W'(32768);
      10:      v = ACC_W'(16384);
      11:      v = ACC_W'(8192);
      12:      v = ACC_W'(4096);
      13:      v = ACC_W'(2048);
      14:      v = ACC_W'(1024);
      15:      v = ACC_W'(512);
      16:      v = ACC_W'(256);
      17:      v = ACC_W'(128);
      18:      v = ACC_W'(64);
      19:      v = ACC_W'(32);
      20:      v = ACC_W'(16);
      21:      v = ACC_W'(8);
      22:      v = ACC_W'(4);
      23:      v = ACC_W'(2);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// File: sv/pta_cordic.sv
`default_nettype none
module pta_cordic #(
  parameter int STAGES = pta_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic signed [pta_pkg::CIN_W-1:0]  in_x,
  input  wire logic signed [pta_pkg::CIN_W-1:0]  in_y,
  output logic signed [pta_pkg::ANG_W-1:0]       angle
);
  import pta_pkg::*;

  localparam int N = (STAGES > TABLE_LEN) ? TABLE_LEN : STAGES;

  logic signed [VEC_W-1:0] x_r [0:N];
  logic signed [VEC_W-1:0] y_r [0:N];
  logic signed [ACC_W-1:0] z_r [0:N];
  logic signed [ANG_W-1:0] angle_r;

  logic signed [VEC_W-1:0] xs, ys;

  assign xs = VEC_W'(in_x) <<< VEC_SHIFT;
  assign ys = VEC_W'(in_y) <<< VEC_SHIFT;

  // quadrant pre-rotation for x < 0
  always_ff @(posedge clk) begin
    if (en) begin
      if (!xs[VEC_W-1]) begin
        x_r[0] <= xs;
        y_r[0] <= ys;
        z_r[0] <= '0;
      end else if (!ys[VEC_W-1]) begin
        x_r[0] <= ys;
        y_r[0] <= -xs;
        z_r[0] <= ACC_W'(ACC_HALF_PI);
      end else begin
        x_r[0] <= -ys;
        y_r[0] <= xs;
        z_r[0] <= -ACC_W'(ACC_HALF_PI);
      end
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic signed [VEC_W-1:0] xsh, ysh;
    assign xsh = x_r[k] >>> k;
    assign ysh = y_r[k] >>> k;
    always_ff @(posedge clk) begin
      if (en) begin
        if (!y_r[k][VEC_W-1]) begin
          x_r[k+1] <= x_r[k] + ysh;
          y_r[k+1] <= y_r[k] - xsh;
          z_r[k+1] <= z_r[k] + atan_entry(k);
        end else begin
          x_r[k+1] <= x_r[k] - ysh;
          y_r[k+1] <= y_r[k] + xsh;
          z_r[k+1] <= z_r[k] - atan_entry(k);
        end
      end
    end
  end

  // round half away from zero, saturate to +-pi
  logic                     z_neg;
  logic [ACC_W-1:0]         z_mag, z_sum;
  logic [ACC_W-ACC_FRAC_SHIFT-1:0] z_rnd;
  logic [ANG_W-1:0]         z_sat;

  always_comb begin
    z_neg = z_r[N][ACC_W-1];
    z_mag = z_neg ? ACC_W'(-z_r[N]) : ACC_W'(z_r[N]);
    z_sum = z_mag + ACC_W'(1 << (ACC_FRAC_SHIFT - 1));
    z_rnd = z_sum[ACC_W-1:ACC_FRAC_SHIFT];
    if (z_rnd > (ACC_W - ACC_FRAC_SHIFT)'(OUT_PI)) begin
      z_sat = ANG_W'(OUT_PI);
    end else begin
      z_sat = z_rnd[ANG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle_r <= z_neg ? -$signed(z_sat) : $signed(z_sat);
    end
  end

  assign angle = angle_r;

endmodule
`default_nettype wire

// File: sv/pan_tilt_aim_angles.sv
`default_nettype none
// Aims a pan/tilt head at the midpoint of two 3-D points, relative to a
// configured pivot: yaw = atan2(dy,dx) (zero inside the deadband or at zero
// range), pitch = -atan2(dz, sqrt(dx^2+dy^2)), each clamped to its limits with
// a flag when the clamp acted. Positions are 2^-16 m, angles 2^-13 rad. Fully
// pipelined: one transaction per cycle while the output is not stalled, through
// 3 front stages, a 25-stage bit-per-stage square root, the unrolled CORDIC
// (stages + 2) and the output register. A stall on the output freezes the whole
// pipeline; write configuration only when idle.
module pan_tilt_aim_angles #(
  parameter int CORDIC_STAGES = pta_pkg::CORDIC_STAGES_DEF,
  parameter int YAW_DEADBAND  = pta_pkg::YAW_DEADBAND_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [pta_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [pta_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [pta_pkg::POS_W-1:0]    in_left_x,
  input  wire logic signed [pta_pkg::POS_W-1:0]    in_left_y,
  input  wire logic signed [pta_pkg::POS_W-1:0]    in_left_z,
  input  wire logic signed [pta_pkg::POS_W-1:0]    in_right_x,
  input  wire logic signed [pta_pkg::POS_W-1:0]    in_right_y,
  input  wire logic signed [pta_pkg::POS_W-1:0]    in_right_z,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [pta_pkg::ANG_W-1:0]         out_pitch_angle,
  output logic signed [pta_pkg::ANG_W-1:0]         out_yaw_angle,
  output logic                                     out_pitch_clamped,
  output logic                                     out_yaw_clamped
);
  import pta_pkg::*;

  localparam int CORDIC_N   = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
  localparam int CORDIC_LAT = CORDIC_N + 2;

  // configuration registers
  logic signed [POS_W-1:0] pivot_x_r, pivot_y_r, pivot_z_r;
  logic signed [ANG_W-1:0] pitch_min_r, pitch_max_r, yaw_min_r, yaw_max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pivot_x_r   <= '0;
      pivot_y_r   <= '0;
      pivot_z_r   <= '0;
      pitch_min_r <= '0;
      pitch_max_r <= '0;
      yaw_min_r   <= '0;
      yaw_max_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PIVOT_X:   pivot_x_r   <= cfg_data;
        REG_PIVOT_Y:   pivot_y_r   <= cfg_data;
        REG_PIVOT_Z:   pivot_z_r   <= cfg_data;
        REG_PITCH_MIN: pitch_min_r <= cfg_data[ANG_W-1:0];
        REG_PITCH_MAX: pitch_max_r <= cfg_data[ANG_W-1:0];
        REG_YAW_MIN:   yaw_min_r   <= cfg_data[ANG_W-1:0];
        REG_YAW_MAX:   yaw_max_r   <= cfg_data[ANG_W-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic out_valid_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  function automatic logic signed [DIFF_W-1:0] mid_diff(
    input logic signed [POS_W-1:0] a,
    input logic signed [POS_W-1:0] b,
    input logic signed [POS_W-1:0] p
  );
    logic signed [DIFF_W-1:0] s;
    logic signed [POS_W-1:0]  m;
    s = DIFF_W'(a) + DIFF_W'(b);
    m = s[DIFF_W-1:1];
    return DIFF_W'(m) - DIFF_W'(p);
  endfunction

  // stage 1: midpoint minus pivot
  logic                      v1_r;
  logic signed [DIFF_W-1:0]  dx1_r, dy1_r, dz1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx1_r <= mid_diff(in_left_x, in_right_x, pivot_x_r);
      dy1_r <= mid_diff(in_left_y, in_right_y, pivot_y_r);
      dz1_r <= mid_diff(in_left_z, in_right_z, pivot_z_r);
    end
  end

  // stage 2: squares and special-case flags
  logic signed [SQ_W-1:0]   px, py;
  logic [DIFF_W-1:0]        ady;
  side_t                    side1;
  side_t                    side2_r;
  logic [SQ_W-2:0]          sqx2_r, sqy2_r;
  logic signed [DIFF_W-1:0] dx2_r, dy2_r, dz2_r;

  always_comb begin
    px  = dx1_r * dx1_r;
    py  = dy1_r * dy1_r;
    ady = dy1_r[DIFF_W-1] ? DIFF_W'(-dy1_r) : DIFF_W'(dy1_r);
    side1.valid       = v1_r;
    side1.zero_range  = (dx1_r == '0) && (dy1_r == '0);
    side1.in_deadband = ady < DIFF_W'(YAW_DEADBAND);
    side1.dz_pos      = !dz1_r[DIFF_W-1] && (dz1_r != '0);
    side1.dz_neg      = dz1_r[DIFF_W-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side2_r <= '0;
    end else if (en) begin
      side2_r <= side1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx2_r <= px[SQ_W-2:0];
      sqy2_r <= py[SQ_W-2:0];
      dx2_r  <= dx1_r;
      dy2_r  <= dy1_r;
      dz2_r  <= dz1_r;
    end
  end

  // stage 3 (sqrt index 0): sum of squares; then one root bit per stage
  logic [SQ_W-1:0]          rem_r  [0:ROOT_W];
  logic [ROOT_W-1:0]        root_r [0:ROOT_W];
  side_t                    sside_r [0:ROOT_W];
  logic signed [DIFF_W-1:0] sdx_r [0:ROOT_W];
  logic signed [DIFF_W-1:0] sdy_r [0:ROOT_W];
  logic signed [DIFF_W-1:0] sdz_r [0:ROOT_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sside_r[0] <= '0;
    end else if (en) begin
      sside_r[0] <= side2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= SQ_W'(sqx2_r) + SQ_W'(sqy2_r);
      root_r[0] <= '0;
      sdx_r[0]  <= dx2_r;
      sdy_r[0]  <= dy2_r;
      sdz_r[0]  <= dz2_r;
    end
  end

  localparam int TR_W = SQ_W + 2;

  for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
    localparam int B = ROOT_W - 1 - j;
    logic [TR_W-1:0] trial;
    logic            take;

    always_comb begin
      trial = ((TR_W'(root_r[j]) << 1) | (TR_W'(1) << B)) << B;
      take  = TR_W'(rem_r[j]) >= trial;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sside_r[j+1] <= '0;
      end else if (en) begin
        sside_r[j+1] <= sside_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j+1]  <= take ? rem_r[j] - trial[SQ_W-1:0] : rem_r[j];
        root_r[j+1] <= take ? (root_r[j] | (ROOT_W'(1) << B)) : root_r[j];
        sdx_r[j+1]  <= sdx_r[j];
        sdy_r[j+1]  <= sdy_r[j];
        sdz_r[j+1]  <= sdz_r[j];
      end
    end
  end

  // CORDIC pair
  logic signed [ANG_W-1:0] yaw_ang, pitch_ang;

  pta_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
    .clk   (clk),
    .en    (en),
    .in_x  (CIN_W'(sdx_r[ROOT_W])),
    .in_y  (CIN_W'(sdy_r[ROOT_W])),
    .angle (yaw_ang)
  );

  pta_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
    .clk   (clk),
    .en    (en),
    .in_x  ($signed({1'b0, root_r[ROOT_W]})),
    .in_y  (CIN_W'(sdz_r[ROOT_W])),
    .angle (pitch_ang)
  );

  side_t cside_r [1:CORDIC_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= CORDIC_LAT; k++) begin
        cside_r[k] <= '0;
      end
    end else if (en) begin
      cside_r[1] <= sside_r[ROOT_W];
      for (int k = 2; k <= CORDIC_LAT; k++) begin
        cside_r[k] <= cside_r[k-1];
      end
    end
  end

  // special cases, clamp, output register
  side_t                   fs;
  logic signed [ANG_W-1:0] yaw_raw, pitch_unc, yaw_hi, pitch_hi, yaw_c, pitch_c;

  always_comb begin
    fs = cside_r[CORDIC_LAT];
    if (fs.in_deadband || fs.zero_range) begin
      yaw_raw = '0;
    end else begin
      yaw_raw = yaw_ang;
    end
    if (!fs.zero_range) begin
      pitch_unc = -pitch_ang;
    end else if (fs.dz_pos) begin
      pitch_unc = -ANG_W'(OUT_HALF_PI);
    end else if (fs.dz_neg) begin
      pitch_unc = ANG_W'(OUT_HALF_PI);
    end else begin
      pitch_unc = '0;
    end
    yaw_hi   = (yaw_raw > yaw_max_r) ? yaw_max_r : yaw_raw;
    yaw_c    = (yaw_hi < yaw_min_r) ? yaw_min_r : yaw_hi;
    pitch_hi = (pitch_unc > pitch_max_r) ? pitch_max_r : pitch_unc;
    pitch_c  = (pitch_hi < pitch_min_r) ? pitch_min_r : pitch_hi;
  end

  logic signed [ANG_W-1:0] pitch_r, yaw_r;
  logic                    pitch_cl_r, yaw_cl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= fs.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pitch_r    <= pitch_c;
      yaw_r      <= yaw_c;
      pitch_cl_r <= pitch_c != pitch_unc;
      yaw_cl_r   <= yaw_c != yaw_raw;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pitch_angle   = pitch_r;
  assign out_yaw_angle     = yaw_r;
  assign out_pitch_clamped = pitch_cl_r;
  assign out_yaw_clamped   = yaw_cl_r;

endmodule
`default_nettype wire

// File: sv/pta_checker.sv
`default_nettype none
module pta_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_stall,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wire logic signed [pta_pkg::ANG_W-1:0]  out_pitch_angle,
  input wire logic signed [pta_pkg::ANG_W-1:0]  out_yaw_angle,
  input wire logic                              out_pitch_clamped,
  input wire logic                              out_yaw_clamped
);
  import pta_pkg::*;

  localparam logic signed [ANG_W-1:0] PI_P = ANG_W'(OUT_PI);
  localparam logic signed [ANG_W-1:0] PI_N = -ANG_W'(OUT_PI);

  // input only backs up when a result sits stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled result");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_pitch_angle)
      && $stable(out_yaw_angle) && $stable(out_pitch_clamped)
      && $stable(out_yaw_clamped)))
    else $error("stalled result changed");

  a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_yaw_clamped) |-> (out_yaw_angle <= PI_P && out_yaw_angle >= PI_N))
    else $error("unclamped yaw outside +-pi");

  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_pitch_clamped) |->
      (out_pitch_angle <= PI_P && out_pitch_angle >= PI_N))
    else $error("unclamped pitch outside +-pi");

endmodule

bind pan_tilt_aim_angles pta_checker u_pta_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_pitch_angle   (out_pitch_angle),
  .out_yaw_angle     (out_yaw_angle),
  .out_pitch_clamped (out_pitch_clamped),
  .out_yaw_clamped   (out_yaw_clamped)
);
`default_nettype wire

// File: sim/pan_tilt_aim_checker.sv
`timescale 1ns / 1ps
module pan_tilt_aim_checker #(
  parameter int CORDIC_STAGES = pta_pkg::CORDIC_STAGES_DEF,
  parameter int YAW_DEADBAND  = pta_pkg::YAW_DEADBAND_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [pta_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pta_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic signed [pta_pkg::POS_W-1:0]     in_left_x,
  input  logic signed [pta_pkg::POS_W-1:0]     in_left_y,
  input  logic signed [pta_pkg::POS_W-1:0]     in_left_z,
  input  logic signed [pta_pkg::POS_W-1:0]     in_right_x,
  input  logic signed [pta_pkg::POS_W-1:0]     in_right_y,
  input  logic signed [pta_pkg::POS_W-1:0]     in_right_z,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic signed [pta_pkg::ANG_W-1:0]     out_pitch_angle,
  input  logic signed [pta_pkg::ANG_W-1:0]     out_yaw_angle,
  input  logic                                 out_pitch_clamped,
  input  logic                                 out_yaw_clamped,
  output int                                   pending,
  output int                                   fail_count
);
  import pta_pkg::*;

  typedef struct packed {
    logic signed [ANG_W-1:0] pitch;
    logic signed [ANG_W-1:0] yaw;
    logic                    pitch_clamped;
    logic                    yaw_clamped;
  } aim_t;

  logic signed [POS_W-1:0] piv_x, piv_y, piv_z;
  logic signed [ANG_W-1:0] lim_pitch_min, lim_pitch_max, lim_yaw_min, lim_yaw_max;
  longint atan_lut [TABLE_LEN];
  aim_t aim_q [$];
  int mism = 0;

  assign fail_count = mism;

  initial begin
    for (int i = 0; i < TABLE_LEN; i++) begin
      atan_lut[i] = $rtoi($atan(2.0 ** (-i)) * (2.0 ** 24) + 0.5);
    end
  end

  // vectoring CORDIC, result in 2^-13 rad
  function automatic longint cordic_angle(input longint y_in, input longint x_in);
    longint x, y, z, t, xs, ys;
    int n;
    x = x_in <<< VEC_SHIFT;
    y = y_in <<< VEC_SHIFT;
    z = 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = ACC_HALF_PI;
      end else begin
        t = x; x = -y; y = t; z = -ACC_HALF_PI;
      end
    end
    n = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
    for (int i = 0; i < n; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + atan_lut[i];
      end else begin
        x = x - ys; y = y + xs; z = z - atan_lut[i];
      end
    end
    if (z >= 0) z = (z + (64'sd1 <<< (ACC_FRAC_SHIFT - 1))) >>> ACC_FRAC_SHIFT;
    else        z = -((-z + (64'sd1 <<< (ACC_FRAC_SHIFT - 1))) >>> ACC_FRAC_SHIFT);
    if (z > OUT_PI)  z = OUT_PI;
    if (z < -OUT_PI) z = -OUT_PI;
    return z;
  endfunction

  function automatic aim_t aim_angles(input logic signed [POS_W-1:0] lx, ly, lz, rx, ry, rz);
    longint dx, dy, dz, sq, root, probe, ady, yaw, pitch, pc, yc;
    aim_t a;
    dx = ((longint'(lx) + longint'(rx)) >>> 1) - longint'(piv_x);
    dy = ((longint'(ly) + longint'(ry)) >>> 1) - longint'(piv_y);
    dz = ((longint'(lz) + longint'(rz)) >>> 1) - longint'(piv_z);
    sq = dx * dx + dy * dy;
    root = 0;
    probe = 64'sd1 <<< 62;
    while (probe > sq) probe = probe >>> 2;
    while (probe != 0) begin
      if (sq >= root + probe) begin
        sq = sq - (root + probe);
        root = (root >>> 1) + probe;
      end else begin
        root = root >>> 1;
      end
      probe = probe >>> 2;
    end
    ady = (dy < 0) ? -dy : dy;
    if (ady < YAW_DEADBAND || root == 0) yaw = 0;
    else yaw = cordic_angle(dy, dx);
    if (root != 0)    pitch = -cordic_angle(dz, root);
    else if (dz > 0)  pitch = -OUT_HALF_PI;
    else if (dz < 0)  pitch = OUT_HALF_PI;
    else              pitch = 0;
    // upper limit first, so inverted limits give the lower one
    pc = pitch;
    if (pc > lim_pitch_max) pc = lim_pitch_max;
    if (pc < lim_pitch_min) pc = lim_pitch_min;
    yc = yaw;
    if (yc > lim_yaw_max) yc = lim_yaw_max;
    if (yc < lim_yaw_min) yc = lim_yaw_min;
    a.pitch = ANG_W'(pc);
    a.yaw = ANG_W'(yc);
    a.pitch_clamped = (pc != pitch);
    a.yaw_clamped = (yc != yaw);
    return a;
  endfunction

  always @(posedge clk) begin
    aim_t want;
    if (!rst_n) begin
      piv_x = '0; piv_y = '0; piv_z = '0;
      lim_pitch_min = '0; lim_pitch_max = '0; lim_yaw_min = '0; lim_yaw_max = '0;
      aim_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PIVOT_X:   piv_x = cfg_data;
          REG_PIVOT_Y:   piv_y = cfg_data;
          REG_PIVOT_Z:   piv_z = cfg_data;
          REG_PITCH_MIN: lim_pitch_min = cfg_data[ANG_W-1:0];
          REG_PITCH_MAX: lim_pitch_max = cfg_data[ANG_W-1:0];
          REG_YAW_MIN:   lim_yaw_min = cfg_data[ANG_W-1:0];
          REG_YAW_MAX:   lim_yaw_max = cfg_data[ANG_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        aim_q.insert(aim_q.size(), aim_angles(in_left_x, in_left_y, in_left_z,
                                              in_right_x, in_right_y, in_right_z));
      end
      if (out_valid && !out_stall) begin
        if (aim_q.size() == 0) begin
          $error("unexpected result transaction");
          mism++;
        end else begin
          want = aim_q.pop_front();
          if (out_pitch_angle !== want.pitch) begin
            $error("pitch_angle: expected %0d, got %0d", want.pitch, out_pitch_angle);
            mism++;
          end
          if (out_yaw_angle !== want.yaw) begin
            $error("yaw_angle: expected %0d, got %0d", want.yaw, out_yaw_angle);
            mism++;
          end
          if (out_pitch_clamped !== want.pitch_clamped) begin
            $error("pitch_clamped: expected %0b, got %0b", want.pitch_clamped,
                   out_pitch_clamped);
            mism++;
          end
          if (out_yaw_clamped !== want.yaw_clamped) begin
            $error("yaw_clamped: expected %0b, got %0b", want.yaw_clamped,
                   out_yaw_clamped);
            mism++;
          end
        end
      end
    end
    pending <= aim_q.size();
  end

endmodule

// File: sim/tb_pan_tilt_aim_angles.sv
`timescale 1ns / 1ps
module tb_pan_tilt_aim_angles;
  import pta_pkg::*;

  localparam int     STAGES      = CORDIC_STAGES_DEF;
  localparam int     DEADBAND    = YAW_DEADBAND_DEF;
  localparam longint POS_MAX     = 8388607;
  localparam longint POS_MIN     = -8388608;
  localparam int     CYCLE_LIMIT = 200000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef logic signed [POS_W-1:0] pos_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  pos_t                    in_left_x = '0, in_left_y = '0, in_left_z = '0;
  pos_t                    in_right_x = '0, in_right_y = '0, in_right_z = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [ANG_W-1:0] out_pitch_angle, out_yaw_angle;
  logic                    out_pitch_clamped, out_yaw_clamped;
  int                      pending, fail_count;
  int                      cycles = 0;
  bit                      calm = 1'b0;
  longint                  piv [3];

  pan_tilt_aim_angles #(.CORDIC_STAGES(STAGES), .YAW_DEADBAND(DEADBAND)) dut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .in_left_x, .in_left_y, .in_left_z,
    .in_right_x, .in_right_y, .in_right_z,
    .out_valid, .out_stall, .out_pitch_angle, .out_yaw_angle,
    .out_pitch_clamped, .out_yaw_clamped
  );

  pan_tilt_aim_checker #(.CORDIC_STAGES(STAGES), .YAW_DEADBAND(DEADBAND)) checker_i (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .in_left_x, .in_left_y, .in_left_z,
    .in_right_x, .in_right_y, .in_right_z,
    .out_valid, .out_stall, .out_pitch_angle, .out_yaw_angle,
    .out_pitch_clamped, .out_yaw_clamped,
    .pending, .fail_count
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_pan_tilt_aim_angles: done, errors");
      $finish;
    end
  end

  always @(posedge clk) out_stall <= !calm && ($urandom_range(0, 99) < 30);

  function automatic longint rnd_pos();
    pos_t p;
    p = pos_t'($urandom);
    return longint'(p);
  endfunction

  function automatic longint rnd_span(input int k);
    return longint'($urandom_range(0, 2 * k)) - k;
  endfunction

  function automatic longint rnd_scaled();
    return rnd_pos() >>> $urandom_range(0, 23);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] lim_word(input longint v);
    logic [CFG_DATA_W-1:0] d;
    d = CFG_DATA_W'($urandom);
    d[ANG_W-1:0] = v[ANG_W-1:0];
    return d;
  endfunction

  // two coordinates whose floor midpoint is target, saturated to range
  function automatic void split_axis(input longint target, output longint l, output longint r);
    longint m, o;
    m = (target > POS_MAX) ? POS_MAX : (target < POS_MIN) ? POS_MIN : target;
    o = longint'($urandom_range(0, 1 << 21)) - (1 << 20);
    l = m + o;
    r = m - o + $urandom_range(0, 1);
    if (l > POS_MAX || l < POS_MIN || r > POS_MAX || r < POS_MIN) begin
      l = m;
      r = m;
    end
  endfunction

  task automatic send_pair(input longint lx, ly, lz, rx, ry, rz);
    while (!calm && $urandom_range(0, 99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_left_x  <= pos_t'(lx);
    in_left_y  <= pos_t'(ly);
    in_left_z  <= pos_t'(lz);
    in_right_x <= pos_t'(rx);
    in_right_y <= pos_t'(ry);
    in_right_z <= pos_t'(rz);
    do @(posedge clk); while (in_stall);
  endtask

  task automatic aim_at(input longint dx, dy, dz);
    longint lx, ly, lz, rx, ry, rz;
    split_axis(piv[0] + dx, lx, rx);
    split_axis(piv[1] + dy, ly, ry);
    split_axis(piv[2] + dz, lz, rz);
    send_pair(lx, ly, lz, rx, ry, rz);
  endtask

  task automatic random_item();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 35)
      send_pair(rnd_pos(), rnd_pos(), rnd_pos(), rnd_pos(), rnd_pos(), rnd_pos());
    else if (sel < 50)
      aim_at(rnd_span(64), rnd_span(64), rnd_span(64));
    else if (sel < 60)
      aim_at(rnd_scaled(), rnd_span(8), rnd_scaled());
    else if (sel < 68)
      aim_at(0, 0, ($urandom_range(0, 3) == 0) ? 0 : rnd_scaled());
    else if (sel < 85)
      aim_at(rnd_scaled(), rnd_scaled(), rnd_scaled());
    else
      aim_at(-longint'($urandom_range(1, POS_MAX)), rnd_span(9), rnd_scaled());
  endtask

  task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
  endtask

  task automatic set_phase(input int k);
    longint pmin, pmax, ymin, ymax;
    case (k)
      1: begin
        piv = '{0, 0, 0};
        pmin = -OUT_PI; pmax = OUT_PI; ymin = -OUT_PI; ymax = OUT_PI;
      end
      2: begin
        piv = '{POS_MAX, POS_MAX, POS_MAX};
        pmin = -32768; pmax = 32767; ymin = -OUT_PI; ymax = OUT_PI;
      end
      3: begin
        piv = '{POS_MIN, POS_MIN, POS_MIN};
        pmin = 1000; pmax = -1000; ymin = OUT_PI; ymax = -OUT_PI;
      end
      4: begin
        piv = '{0, 0, 0};
        pmin = -100; pmax = 100; ymin = 0; ymax = 0;
      end
      default: begin
        piv = '{rnd_scaled(), rnd_scaled(), rnd_scaled()};
        pmin = -longint'($urandom_range(0, OUT_PI));
        pmax = $urandom_range(0, OUT_PI);
        ymin = -longint'($urandom_range(0, OUT_PI));
        ymax = $urandom_range(0, OUT_PI);
      end
    endcase
    cfg_put(REG_PIVOT_X, CFG_DATA_W'(piv[0]));
    cfg_put(REG_PIVOT_Y, CFG_DATA_W'(piv[1]));
    cfg_put(REG_PIVOT_Z, CFG_DATA_W'(piv[2]));
    cfg_put(REG_PITCH_MIN, lim_word(pmin));
    cfg_put(REG_PITCH_MAX, lim_word(pmax));
    cfg_put(REG_YAW_MIN, lim_word(ymin));
    cfg_put(REG_YAW_MAX, lim_word(ymax));
    cfg_put(REG_UNUSED, CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    piv = '{0, 0, 0};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // reset values: zero pivot, zero limits
    repeat (10) random_item();
    settle();
    for (int k = 1; k <= 9; k++) begin
      set_phase(k);
      calm = (k == 5);
      if (k == 1) begin
        send_pair(0, 0, 0, 0, 0, 0);
        send_pair(POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX);
        send_pair(POS_MIN, POS_MIN, POS_MIN, POS_MIN, POS_MIN, POS_MIN);
        send_pair(POS_MAX, POS_MAX, POS_MAX, POS_MIN, POS_MIN, POS_MIN);
        send_pair(1, 1, 1, 0, 0, 0);
        send_pair(-1, -1, -1, 0, 0, 0);
        aim_at(0, 0, 1000);
        aim_at(0, 0, -1000);
        aim_at(5000, DEADBAND - 1, 0);
        aim_at(5000, DEADBAND, 0);
        aim_at(5000, -DEADBAND, 0);
        aim_at(5000, -(DEADBAND - 1), 0);
        aim_at(-5000, DEADBAND, 10);
        aim_at(-5000, -DEADBAND, -10);
        aim_at(-5000, 3000, 0);
        aim_at(-5000, -3000, 0);
        aim_at(0, 8000000, 0);
        aim_at(0, -8000000, 0);
        aim_at(1, 0, 8000000);
        aim_at(1, 0, -8000000);
        aim_at(POS_MIN, POS_MAX, POS_MIN);
        aim_at(POS_MAX, POS_MIN, POS_MAX);
      end else begin
        repeat (50) random_item();
      end
      settle();
    end
    calm = 1'b0;
    repeat (64) @(posedge clk);
    if (fail_count == 0)
      $display("tb_pan_tilt_aim_angles: done, clean");
    else
      $display("tb_pan_tilt_aim_angles: done, errors");
    $finish;
  end

endmodule

// File: sim.f
sv/pta_pkg.sv
sv/pta_cordic.sv
sv/pan_tilt_aim_angles.sv
sv/pta_checker.sv
sim/pan_tilt_aim_checker.sv
sim/tb_pan_tilt_aim_angles.sv
